FILE: design/alet_pkg.sv
`timescale 1ns / 1ps

package alet_pkg;

	localparam int VTX_W       = 5;
	localparam int EDGE_W      = 16;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 8;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_VERTEX = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ROW_FULL   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED     = 2'd2;

	localparam logic [4:0] VERTEX_COUNT_RST = 5'd16;
	localparam logic [3:0] DEGREE_LIMIT_RST = 4'd8;

	typedef struct packed {
		logic [4:0] vertex_count;
		logic [3:0] degree_limit;
		logic       weighted;
	} cfg_t;

	typedef struct packed {
		logic bad_vertex;
		logic remove;
		logic mirror;
		logic self_loop;
	} cmd_t;

endpackage

FILE: design/alet_front.sv
`timescale 1ns / 1ps

module alet_front #(
	parameter int VERTICES    = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  alet_pkg::cfg_t                   cfg,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic                             mode,
	input  logic [alet_pkg::VTX_W-1:0]       origin_vertex,
	input  logic [alet_pkg::VTX_W-1:0]       destination_vertex,
	input  logic                             directed,
	input  logic signed [alet_pkg::EDGE_W-1:0] edge_weight,
	output logic                             q_valid,
	input  logic                             q_pop,
	output alet_pkg::cmd_t                   q_cmd,
	output logic [$clog2(VERTICES)-1:0]      q_ra,
	output logic [$clog2(VERTICES)-1:0]      q_rb,
	output logic [WEIGHT_BITS-1:0]           q_w
);
	import alet_pkg::*;

	localparam int     ROW_W  = $clog2(VERTICES);
	localparam int     QDEPTH = 2;
	localparam int     PTR_W  = $clog2(QDEPTH);
	localparam int     CNT_W  = $clog2(QDEPTH + 1);
	localparam longint W_HI   = (longint'(1) << (WEIGHT_BITS - 1)) - 1;
	localparam longint W_LO   = -W_HI - 1;

	cmd_t                   in_cmd;
	longint                 w_ext;
	longint                 w_sat;
	logic [WEIGHT_BITS-1:0] in_w;
	logic                   push;

	cmd_t                   cmd_mem_q [QDEPTH];
	logic [ROW_W-1:0]       ra_mem_q  [QDEPTH];
	logic [ROW_W-1:0]       rb_mem_q  [QDEPTH];
	logic [WEIGHT_BITS-1:0] w_mem_q   [QDEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;

	always_comb begin
		in_cmd.bad_vertex = (origin_vertex >= cfg.vertex_count)
			|| (destination_vertex >= cfg.vertex_count)
			|| (32'(origin_vertex) >= VERTICES)
			|| (32'(destination_vertex) >= VERTICES);
		in_cmd.remove    = (mode == MODE_REMOVE);
		in_cmd.mirror    = (directed == 1'b0);
		in_cmd.self_loop = (origin_vertex == destination_vertex);
		w_ext = longint'(edge_weight);
		if (w_ext > W_HI) begin
			w_sat = W_HI;
		end else if (w_ext < W_LO) begin
			w_sat = W_LO;
		end else begin
			w_sat = w_ext;
		end
		in_w = WEIGHT_BITS'(w_sat);
	end

	assign s_tready = (count_q != CNT_W'(QDEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_cmd    = cmd_mem_q[rd_ptr_q];
	assign q_ra     = ra_mem_q[rd_ptr_q];
	assign q_rb     = rb_mem_q[rd_ptr_q];
	assign q_w      = w_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem_q[wr_ptr_q] <= in_cmd;
			ra_mem_q[wr_ptr_q]  <= ROW_W'(origin_vertex);
			rb_mem_q[wr_ptr_q]  <= ROW_W'(destination_vertex);
			w_mem_q[wr_ptr_q]   <= in_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/alet_back.sv
`timescale 1ns / 1ps

module alet_back #(
	parameter int VERTICES    = 16,
	parameter int MAX_DEGREE  = 8,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  alet_pkg::cfg_t                cfg,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  alet_pkg::cmd_t                q_cmd,
	input  logic [$clog2(VERTICES)-1:0]   q_ra,
	input  logic [$clog2(VERTICES)-1:0]   q_rb,
	input  logic [WEIGHT_BITS-1:0]        q_w,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [alet_pkg::STATUS_W-1:0] m_status
);
	import alet_pkg::*;

	localparam int ROW_W     = $clog2(VERTICES);
	localparam int SLOT_W    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
	localparam int ADDR_W    = ROW_W + SLOT_W;
	localparam int MEM_DEPTH = VERTICES * (1 << SLOT_W);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_IRA  = 13'b0000000000010,
		S_IRB  = 13'b0000000000100,
		S_ICHK = 13'b0000000001000,
		S_IWA  = 13'b0000000010000,
		S_IWB  = 13'b0000000100000,
		S_RDEG = 13'b0000001000000,
		S_RDGW = 13'b0000010000000,
		S_RRQ  = 13'b0000100000000,
		S_RCMP = 13'b0001000000000,
		S_RLRQ = 13'b0010000000000,
		S_RMOV = 13'b0100000000000,
		S_FIN  = 13'b1000000000000
	} back_state_t;

	back_state_t            state_q;
	cmd_t                   cmd_q;
	logic [ROW_W-1:0]       ra_q;
	logic [ROW_W-1:0]       rb_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [ROW_W-1:0]       row_q;
	logic [ROW_W-1:0]       tgt_q;
	logic                   pass_q;
	logic [DEG_W-1:0]       da_q;
	logic [DEG_W-1:0]       db_q;
	logic [DEG_W-1:0]       d_q;
	logic [DEG_W-1:0]       idx_q;
	logic [SLOT_W-1:0]      hole_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;

	logic [ROW_W-1:0]       nbr_mem [MEM_DEPTH];
	logic [WEIGHT_BITS-1:0] wt_mem  [MEM_DEPTH];
	logic [DEG_W-1:0]       deg_mem [VERTICES];
	logic [VERTICES-1:0]    deg_valid_q;
	logic                   deg_hit_q;
	logic [DEG_W-1:0]       deg_rd_q;
	logic [ROW_W-1:0]       nbr_rd_q;
	logic [WEIGHT_BITS-1:0] w_rd_q;

	logic [DEG_W-1:0]       deg_val;
	logic [DEG_W-1:0]       last_idx;
	logic [ROW_W-1:0]       row_b;
	logic [ROW_W-1:0]       deg_raddr;
	logic [ADDR_W-1:0]      mem_raddr;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic [ROW_W-1:0]       mem_wdata;
	logic                   wt_we;
	logic [WEIGHT_BITS-1:0] wt_wdata;
	logic                   deg_we;
	logic [ROW_W-1:0]       deg_waddr;
	logic [DEG_W-1:0]       deg_wdata;
	int                     lim;
	logic                   room;
	logic                   out_free;

	assign deg_val  = deg_hit_q ? deg_rd_q : '0;
	assign last_idx = d_q - DEG_W'(1);
	assign row_b    = cmd_q.self_loop ? ra_q : rb_q;
	assign out_free = !out_valid_q || m_tready;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign m_tvalid = out_valid_q;
	assign m_status = out_status_q;

	always_comb begin
		lim = (int'(cfg.degree_limit) < MAX_DEGREE) ? int'(cfg.degree_limit) : MAX_DEGREE;
		if (cmd_q.mirror && cmd_q.self_loop) begin
			room = (int'(da_q) + 2) <= lim;
		end else if (cmd_q.mirror) begin
			room = (int'(da_q) < lim) && (int'(deg_val) < lim);
		end else begin
			room = int'(da_q) < lim;
		end
	end

	always_comb begin
		deg_raddr = ra_q;
		mem_raddr = {row_q, idx_q[SLOT_W-1:0]};
		mem_we    = 1'b0;
		mem_waddr = {row_q, hole_q};
		mem_wdata = nbr_rd_q;
		wt_we     = 1'b0;
		wt_wdata  = w_rd_q;
		deg_we    = 1'b0;
		deg_waddr = row_q;
		deg_wdata = last_idx;
		case (state_q)
			S_IRB: begin
				deg_raddr = rb_q;
			end
			S_RDEG: begin
				deg_raddr = row_q;
			end
			S_RLRQ: begin
				mem_raddr = {row_q, last_idx[SLOT_W-1:0]};
			end
			S_IWA: begin
				mem_we    = 1'b1;
				mem_waddr = {ra_q, da_q[SLOT_W-1:0]};
				mem_wdata = rb_q;
				wt_we     = cfg.weighted;
				wt_wdata  = w_q;
				deg_we    = 1'b1;
				deg_waddr = ra_q;
				deg_wdata = da_q + DEG_W'(1);
			end
			S_IWB: begin
				mem_we    = 1'b1;
				mem_waddr = {row_b, db_q[SLOT_W-1:0]};
				mem_wdata = ra_q;
				wt_we     = cfg.weighted;
				wt_wdata  = w_q;
				deg_we    = 1'b1;
				deg_waddr = row_b;
				deg_wdata = db_q + DEG_W'(1);
			end
			S_RMOV: begin
				mem_we = 1'b1;
				wt_we  = cfg.weighted;
				deg_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			nbr_mem[mem_waddr] <= mem_wdata;
		end
		nbr_rd_q <= nbr_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[mem_waddr] <= wt_wdata;
		end
		w_rd_q <= wt_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		deg_rd_q <= deg_mem[deg_raddr];
	end

	// rows never written read as degree zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_valid_q <= '0;
			deg_hit_q   <= 1'b0;
		end else begin
			if (deg_we) begin
				deg_valid_q[deg_waddr] <= 1'b1;
			end
			deg_hit_q <= deg_valid_q[deg_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			ra_q  <= q_ra;
			rb_q  <= q_rb;
			w_q   <= q_w;
			row_q <= q_ra;
			tgt_q <= q_rb;
		end
		case (state_q)
			S_IRB: begin
				da_q <= deg_val;
			end
			S_ICHK: begin
				db_q <= cmd_q.self_loop ? (da_q + DEG_W'(1)) : deg_val;
			end
			S_RDGW: begin
				d_q   <= deg_val;
				idx_q <= '0;
			end
			S_RCMP: begin
				hole_q <= idx_q[SLOT_W-1:0];
				idx_q  <= idx_q + DEG_W'(1);
			end
			S_RMOV: begin
				row_q <= rb_q;
				tgt_q <= ra_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pass_q       <= 1'b0;
			status_q     <= ST_DONE;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_DONE;
		end else begin
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= status_q;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						pass_q <= 1'b0;
						if (q_cmd.bad_vertex) begin
							status_q <= ST_BAD_VERTEX;
							state_q  <= S_FIN;
						end else if (q_cmd.remove) begin
							state_q <= S_RDEG;
						end else begin
							state_q <= S_IRA;
						end
					end
				end
				S_IRA: state_q <= S_IRB;
				S_IRB: state_q <= S_ICHK;
				S_ICHK: begin
					if (room) begin
						state_q <= S_IWA;
					end else begin
						status_q <= ST_ROW_FULL;
						state_q  <= S_FIN;
					end
				end
				S_IWA: begin
					status_q <= ST_DONE;
					state_q  <= cmd_q.mirror ? S_IWB : S_FIN;
				end
				S_IWB: state_q <= S_FIN;
				S_RDEG: state_q <= S_RDGW;
				S_RDGW: begin
					if (deg_val == '0) begin
						status_q <= pass_q ? ST_DONE : ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_RRQ;
					end
				end
				S_RRQ: state_q <= S_RCMP;
				S_RCMP: begin
					if (nbr_rd_q == tgt_q) begin
						state_q <= S_RLRQ;
					end else if ((idx_q + DEG_W'(1)) == d_q) begin
						status_q <= pass_q ? ST_DONE : ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_RRQ;
					end
				end
				S_RLRQ: state_q <= S_RMOV;
				S_RMOV: begin
					status_q <= ST_DONE;
					if (!pass_q && cmd_q.mirror) begin
						pass_q  <= 1'b1;
						state_q <= S_RDEG;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/adjacency_list_edge_table_core.sv
`timescale 1ns / 1ps
// channel  width  fields (lowest bit first)
// s_       tdata 32  origin_vertex[4:0] destination_vertex[9:5] edge_weight[25:10]
//          tuser 2   mode[0] directed[1]
// m_       tdata 8   status[1:0]
// cfg_     wdata 5   index 0 vertex_count, 1 degree_limit, 2 weighted
//
// Items queue two deep ahead of a sequencer whose tables have one read and one write
// port each; one item at a time. A bad vertex goes straight to its status. Insert reads
// both degrees, checks room, writes the first row, then the second when mirrored. Remove
// searches a row slot by slot, moves its last entry into the hole; mirror adds row two.
// The result register lets the next item proceed while a status waits for m_tready.
// Reset is asynchronous; degree counts clear at once through per-row valid flags.

module adjacency_list_edge_table_core #(
	parameter int VERTICES    = 16,
	parameter int MAX_DEGREE  = 8,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [alet_pkg::IN_TDATA_W-1:0]    s_tdata,  // origin, destination, edge_weight
	input  logic [alet_pkg::IN_TUSER_W-1:0]    s_tuser,  // mode, directed
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [alet_pkg::OUT_TDATA_W-1:0]   m_tdata,  // status
	input  logic                               cfg_wen,
	input  logic [alet_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [alet_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import alet_pkg::*;

	localparam int ROW_W = $clog2(VERTICES);

	cfg_t                   cfg_q;
	logic                   q_valid;
	logic                   q_pop;
	cmd_t                   q_cmd;
	logic [ROW_W-1:0]       q_ra;
	logic [ROW_W-1:0]       q_rb;
	logic [WEIGHT_BITS-1:0] q_w;
	logic [STATUS_W-1:0]    status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vertex_count <= VERTEX_COUNT_RST;
			cfg_q.degree_limit <= DEGREE_LIMIT_RST;
			cfg_q.weighted     <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				CFG_VERTEX_COUNT: cfg_q.vertex_count <= cfg_wdata;
				CFG_DEGREE_LIMIT: cfg_q.degree_limit <= cfg_wdata[3:0];
				CFG_WEIGHTED:     cfg_q.weighted     <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	alet_front #(
		.VERTICES    (VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.mode               (s_tuser[0]),
		.origin_vertex      (s_tdata[4:0]),
		.destination_vertex (s_tdata[9:5]),
		.directed           (s_tuser[1]),
		.edge_weight        (s_tdata[25:10]),
		.q_valid            (q_valid),
		.q_pop              (q_pop),
		.q_cmd              (q_cmd),
		.q_ra               (q_ra),
		.q_rb               (q_rb),
		.q_w                (q_w)
	);

	alet_back #(
		.VERTICES    (VERTICES),
		.MAX_DEGREE  (MAX_DEGREE),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_cmd    (q_cmd),
		.q_ra     (q_ra),
		.q_rb     (q_rb),
		.q_w      (q_w),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_status (status)
	);

	assign m_tdata = OUT_TDATA_W'(status);

endmodule

FILE: design/alet_checker.sv
`timescale 1ns / 1ps

module alet_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [alet_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import alet_pkg::*;

	logic [3:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({s_tvalid && s_tready, m_tvalid && m_tready})
				2'b10:   pending_q <= pending_q + 4'd1;
				2'b01:   pending_q <= pending_q - 4'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 4'd0)
		else $error("result without an outstanding item");

	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> pending_q != 4'd0)
		else $error("input stalled with nothing in flight");

	a_status_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:STATUS_W] == '0)
		else $error("status padding bits set");

endmodule

bind adjacency_list_edge_table_core alet_checker u_alet_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
